// ===== hw/rtl/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared constants, types and width helpers of the ray / sphere intersection
// block.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int TOL_WIDTH       = 16;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(1);
    localparam int QUEUE_DEPTH     = 4;

    typedef struct packed {
        logic interior;
        logic miss;
        logic tangent;
    } rsi_class_t;

    function automatic int dir_width(input int f);
        return f + 2;
    endfunction

    function automatic int a1_width(input int c, input int f);
        return c + f + 5;
    endfunction

    function automatic int disc_width(input int c, input int f);
        return 2 * c + 2 * f + 12;
    endfunction

    function automatic int pass_width(input int c, input int f);
        return 3 * c + 3 * dir_width(f);
    endfunction

    function automatic int queue_width(input int c, input int f);
        return pass_width(c, f) + a1_width(c, f) + disc_width(c, f) - 1
            + $bits(rsi_class_t);
    endfunction

endpackage

// ===== hw/rtl/rsi_if.sv =====
// ----------------------------------------------------------------------------
// rsi_if
// Channel interfaces of the ray / sphere intersection block.
// ----------------------------------------------------------------------------
interface rsi_req_if #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic signed [COORD_WIDTH-1:0] origin_z;
    logic signed [FRAC_BITS+1:0]   dir_x;
    logic signed [FRAC_BITS+1:0]   dir_y;
    logic signed [FRAC_BITS+1:0]   dir_z;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] center_z;
    logic        [COORD_WIDTH-2:0] sphere_radius;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               center_x, center_y, center_z, sphere_radius,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               center_x, center_y, center_z, sphere_radius,
        output ready
    );
endinterface

interface rsi_rsp_if #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic                          clipped;

    modport source (output valid, hit, point_x, point_y, point_z, clipped, input ready);
    modport sink (input valid, hit, point_x, point_y, point_z, clipped, output ready);
endinterface

interface rsi_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rsi_pkg::TOL_WIDTH-1:0] tangent_tolerance;

    modport source (output valid, tangent_tolerance, input ready);
    modport sink (input valid, tangent_tolerance, output ready);
endinterface

// ===== hw/rtl/rsi_queue.sv =====
// ----------------------------------------------------------------------------
// rsi_queue
// Small first-in first-out buffer between the front and back pipelines.
// ----------------------------------------------------------------------------
module rsi_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rsi_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/rsi_front.sv =====
// ----------------------------------------------------------------------------
// rsi_front
// Seven-stage front pipeline: forms a0, a1 and the discriminant and
// classifies each item as inside, miss or tangent.
// ----------------------------------------------------------------------------
module rsi_front #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    rsi_req_if.sink                                req,
    input  logic [rsi_pkg::TOL_WIDTH-1:0]          tol,
    input  logic                                   q_full,
    output logic                                   q_push,
    output logic [rsi_pkg::queue_width(COORD_WIDTH, FRAC_BITS)-1:0] q_data
);
    localparam int C      = COORD_WIDTH;
    localparam int DW     = C + 1;
    localparam int DRW    = rsi_pkg::dir_width(FRAC_BITS);
    localparam int RW     = C - 1;
    localparam int S_W    = 2 * C + 3;
    localparam int A1_W   = rsi_pkg::a1_width(C, FRAC_BITS);
    localparam int K      = A1_W / 2;
    localparam int HW     = A1_W - K;
    localparam int SQ_W   = 2 * A1_W + 1;
    localparam int DISC_W = rsi_pkg::disc_width(C, FRAC_BITS);
    localparam int TSH_W  = rsi_pkg::TOL_WIDTH + 3 * FRAC_BITS;
    localparam int CMP_W  = (DISC_W > TSH_W) ? DISC_W : TSH_W;
    localparam int PASS_W = rsi_pkg::pass_width(C, FRAC_BITS);

    logic [7:1] fv_reg;
    logic       adv;

    logic signed [C-1:0]   in_o [3];
    logic signed [DRW-1:0] in_dir [3];
    logic signed [C-1:0]   in_c [3];

    logic [PASS_W-1:0] pass_reg [1:7];

    logic signed [DW-1:0]       d1_reg [3];
    logic        [RW-1:0]       r1_reg;
    logic signed [2*DW-1:0]     dd2_reg [3];
    logic signed [DW+DRW-1:0]   da2_reg [3];
    logic        [2*RW-1:0]     rr2_reg;
    logic signed [S_W-1:0]      s3_reg, s4_reg, s5_reg, s6_reg;
    logic signed [A1_W-1:0]     a1_3_reg, a1_4_reg, a1_5_reg, a1_6_reg, a1_7_reg;
    logic signed [2*HW-1:0]     hh4_reg;
    logic signed [HW+K:0]       hl4_reg;
    logic        [2*K-1:0]      ll4_reg;
    logic        [SQ_W-1:0]     a1sq5_reg;
    logic signed [DISC_W-1:0]   disc6_reg;
    logic        [DISC_W-2:0]   disc_mag7_reg;
    rsi_pkg::rsi_class_t        cls7_reg;

    logic signed [HW-1:0]       a1_hi;
    logic        [K-1:0]        a1_lo;
    logic        [DISC_W-2:0]   disc_mag;
    rsi_pkg::rsi_class_t        cls;

    assign adv       = !fv_reg[7] || !q_full;
    assign req.ready = adv;
    assign q_push    = fv_reg[7] && !q_full;
    assign q_data    = {pass_reg[7], a1_7_reg, disc_mag7_reg, cls7_reg};

    always_comb
    begin
        in_o[0]   = req.origin_x;
        in_o[1]   = req.origin_y;
        in_o[2]   = req.origin_z;
        in_dir[0] = req.dir_x;
        in_dir[1] = req.dir_y;
        in_dir[2] = req.dir_z;
        in_c[0]   = req.center_x;
        in_c[1]   = req.center_y;
        in_c[2]   = req.center_z;
    end

    assign a1_hi = a1_3_reg[A1_W-1:K];
    assign a1_lo = a1_3_reg[K-1:0];

    always_comb
    begin
        disc_mag     = disc6_reg[DISC_W-1] ? '0 : disc6_reg[DISC_W-2:0];
        cls.interior = s6_reg[S_W-1] || (s6_reg == '0);
        cls.miss     = !cls.interior && (!a1_6_reg[A1_W-1] || disc6_reg[DISC_W-1]);
        cls.tangent  = !cls.interior && !cls.miss
            && (CMP_W'(disc_mag) < (CMP_W'(tol) << (3 * FRAC_BITS)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else if (adv)
        begin
            fv_reg <= {fv_reg[6:1], req.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pass_reg[1] <= {in_o[0], in_o[1], in_o[2], in_dir[0], in_dir[1], in_dir[2]};
            for (int k = 2; k <= 7; k++)
            begin
                pass_reg[k] <= pass_reg[k-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                d1_reg[i]  <= $signed({in_o[i][C-1], in_o[i]}) - $signed({in_c[i][C-1], in_c[i]});
                dd2_reg[i] <= d1_reg[i] * d1_reg[i];
                da2_reg[i] <= d1_reg[i] * $signed(pass_reg[1][(2-i)*DRW +: DRW]);
            end
            r1_reg  <= req.sphere_radius;
            rr2_reg <= r1_reg * r1_reg;

            s3_reg   <= S_W'(dd2_reg[0]) + S_W'(dd2_reg[1]) + S_W'(dd2_reg[2])
                        - S_W'(rr2_reg);
            a1_3_reg <= A1_W'(da2_reg[0]) + A1_W'(da2_reg[1]) + A1_W'(da2_reg[2]);

            s4_reg   <= s3_reg;
            a1_4_reg <= a1_3_reg;
            hh4_reg  <= a1_hi * a1_hi;
            hl4_reg  <= a1_hi * $signed({1'b0, a1_lo});
            ll4_reg  <= a1_lo * a1_lo;

            s5_reg    <= s4_reg;
            a1_5_reg  <= a1_4_reg;
            a1sq5_reg <= (SQ_W'(hh4_reg) << (2 * K)) + (SQ_W'(hl4_reg) << (K + 1))
                         + SQ_W'(ll4_reg);

            s6_reg    <= s5_reg;
            a1_6_reg  <= a1_5_reg;
            disc6_reg <= DISC_W'(a1sq5_reg) - (DISC_W'(s5_reg) <<< (2 * FRAC_BITS));

            a1_7_reg      <= a1_6_reg;
            disc_mag7_reg <= disc_mag;
            cls7_reg      <= cls;
        end
    end

endmodule

// ===== hw/rtl/rsi_back.sv =====
// ----------------------------------------------------------------------------
// rsi_back
// Back pipeline: one square-root bit per stage, then the hit distance, the
// scaled direction and the saturated hit point.
// ----------------------------------------------------------------------------
module rsi_back #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_valid,
    input  logic [rsi_pkg::queue_width(COORD_WIDTH, FRAC_BITS)-1:0] q_data,
    output logic                                   q_pop,
    rsi_rsp_if.source                              rsp
);
    localparam int C      = COORD_WIDTH;
    localparam int DRW    = rsi_pkg::dir_width(FRAC_BITS);
    localparam int A1_W   = rsi_pkg::a1_width(C, FRAC_BITS);
    localparam int DISC_W = rsi_pkg::disc_width(C, FRAC_BITS);
    localparam int PASS_W = rsi_pkg::pass_width(C, FRAC_BITS);
    localparam int FLW    = $bits(rsi_pkg::rsi_class_t);
    localparam int CW     = PASS_W + A1_W + FLW;
    localparam int R      = (DISC_W + 1) / 2;
    localparam int X_W    = 2 * R;
    localparam int T_W    = ((A1_W > R) ? A1_W : R + 1) + 2;
    localparam int K2     = T_W / 2;
    localparam int TH     = T_W - K2;
    localparam int PROD_W = T_W + DRW;
    localparam int SUM_W  = ((PROD_W > 3 * FRAC_BITS) ? PROD_W : 3 * FRAC_BITS) + 2;
    localparam int P_W    = SUM_W + 1;
    localparam int NB     = R + 5;
    localparam logic signed [P_W-1:0] CMAX = {{(P_W-C+1){1'b0}}, {(C-1){1'b1}}};
    localparam logic signed [P_W-1:0] CMIN = {{(P_W-C+1){1'b1}}, {(C-1){1'b0}}};

    logic [NB-1:0] bv_reg;
    logic          adv;

    logic [X_W-1:0] x_reg   [0:R];
    logic [X_W-1:0] res_reg [0:R];
    logic [CW-1:0]  c_reg   [0:R];
    logic [X_W-1:0] trial   [R];
    logic           take    [R];

    rsi_pkg::rsi_class_t     sq_cls;
    logic signed [A1_W-1:0]  sq_a1;
    logic        [R-1:0]     root;
    logic signed [T_W-1:0]   t_next;

    logic signed [T_W-1:0]       t_reg;
    logic [PASS_W-1:0]           pass_t_reg;
    logic                        miss_t_reg;
    logic signed [TH+DRW-1:0]    ph_reg [3];
    logic signed [K2+DRW:0]      pl_reg [3];
    logic [3*C-1:0]              o_m_reg, o_a_reg;
    logic                        miss_m_reg, miss_a_reg;
    logic signed [SUM_W-1:0]     sum_reg [3];

    logic signed [P_W-1:0]       p_full [3];
    logic signed [C-1:0]         p_sat  [3];
    logic [2:0]                  p_clip;

    logic                        hit_reg;
    logic signed [C-1:0]         point_reg [3];
    logic                        clipped_reg;

    assign adv       = !bv_reg[NB-1] || rsp.ready;
    assign q_pop     = adv && q_valid;
    assign rsp.valid = bv_reg[NB-1];
    assign rsp.hit     = hit_reg;
    assign rsp.point_x = point_reg[0];
    assign rsp.point_y = point_reg[1];
    assign rsp.point_z = point_reg[2];
    assign rsp.clipped = clipped_reg;

    always_comb
    begin
        for (int j = 0; j < R; j++)
        begin
            trial[j] = res_reg[j] + (X_W'(1) << (2 * (R - 1 - j)));
            take[j]  = (x_reg[j] >= trial[j]);
        end
    end

    always_comb
    begin
        sq_cls = c_reg[R][FLW-1:0];
        sq_a1  = c_reg[R][FLW +: A1_W];
        root   = res_reg[R][R-1:0];
        priority if (sq_cls.interior)
        begin
            t_next = -T_W'(sq_a1) + T_W'(root);
        end
        else if (sq_cls.tangent)
        begin
            t_next = -T_W'(sq_a1);
        end
        else
        begin
            t_next = -T_W'(sq_a1) - T_W'(root);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_full[i] = P_W'(sum_reg[i] >>> (3 * FRAC_BITS))
                        + P_W'($signed(o_a_reg[(2-i)*C +: C]));
            if (p_full[i] > CMAX)
            begin
                p_sat[i]  = CMAX[C-1:0];
                p_clip[i] = 1'b1;
            end
            else if (p_full[i] < CMIN)
            begin
                p_sat[i]  = CMIN[C-1:0];
                p_clip[i] = 1'b1;
            end
            else
            begin
                p_sat[i]  = p_full[i][C-1:0];
                p_clip[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg <= '0;
        end
        else if (adv)
        begin
            bv_reg <= {bv_reg[NB-2:0], q_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0]   <= X_W'(q_data[FLW +: DISC_W-1]);
            res_reg[0] <= '0;
            c_reg[0]   <= {q_data[FLW+DISC_W-1 +: PASS_W+A1_W], q_data[FLW-1:0]};
            for (int j = 0; j < R; j++)
            begin
                x_reg[j+1]   <= take[j] ? x_reg[j] - trial[j] : x_reg[j];
                res_reg[j+1] <= take[j] ? (res_reg[j] >> 1) + (X_W'(1) << (2 * (R - 1 - j)))
                                        : (res_reg[j] >> 1);
                c_reg[j+1]   <= c_reg[j];
            end

            t_reg      <= t_next;
            pass_t_reg <= c_reg[R][FLW+A1_W +: PASS_W];
            miss_t_reg <= sq_cls.miss;

            for (int i = 0; i < 3; i++)
            begin
                ph_reg[i] <= $signed(t_reg[T_W-1:K2])
                             * $signed(pass_t_reg[(2-i)*DRW +: DRW]);
                pl_reg[i] <= $signed({1'b0, t_reg[K2-1:0]})
                             * $signed(pass_t_reg[(2-i)*DRW +: DRW]);
                sum_reg[i] <= (SUM_W'(ph_reg[i]) <<< K2) + SUM_W'(pl_reg[i])
                              + (SUM_W'(1) << (3 * FRAC_BITS - 1));
            end
            o_m_reg    <= pass_t_reg[3*DRW +: 3*C];
            miss_m_reg <= miss_t_reg;
            o_a_reg    <= o_m_reg;
            miss_a_reg <= miss_m_reg;

            hit_reg     <= !miss_a_reg;
            clipped_reg <= !miss_a_reg && (p_clip != '0);
            for (int i = 0; i < 3; i++)
            begin
                point_reg[i] <= miss_a_reg ? '0 : p_sat[i];
            end
        end
    end

endmodule

// ===== hw/rtl/ray_sphere_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// Pipelined ray / sphere intersection test with a hit point output.
// ----------------------------------------------------------------------------
// Throughput is one item per cycle while the output is not stalled; the square root takes one pipeline stage per bit.
// A four-entry queue lets the front take items while the output is stalled.
// Reset clears all valid flags and sets the tangent tolerance to one.
module ray_sphere_intersect #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rsi_req_if.sink    req,
    rsi_rsp_if.source  rsp,
    rsi_cfg_if.sink    cfg
);
    localparam int QW = rsi_pkg::queue_width(COORD_WIDTH, FRAC_BITS);

    logic [rsi_pkg::TOL_WIDTH-1:0] tol_reg;
    logic                          q_full;
    logic                          q_push;
    logic [QW-1:0]                 q_push_data;
    logic                          q_pop;
    logic                          q_valid;
    logic [QW-1:0]                 q_pop_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= rsi_pkg::TOL_RESET;
        end
        else if (cfg.valid)
        begin
            tol_reg <= cfg.tangent_tolerance;
        end
    end

    rsi_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .tol    (tol_reg),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_push_data)
    );

    rsi_queue #(
        .WIDTH (QW),
        .DEPTH (rsi_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_pop_data)
    );

    rsi_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_pop_data),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule

// ===== verif/rsi_checker.sv =====
// ----------------------------------------------------------------------------
// rsi_checker
// Watches the request, response and configuration channels of the ray /
// sphere intersection block. It predicts each hit result in wide exact
// arithmetic and compares every response item with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rsi_checker (
    input  logic clk,
    input  logic rst_n,
    rsi_req_if   req,
    rsi_rsp_if   rsp,
    rsi_cfg_if   cfg,
    output int   fail_count,
    output int   pending
);

    typedef struct packed {
        logic        hit;
        logic [31:0] point_x;
        logic [31:0] point_y;
        logic [31:0] point_z;
        logic        clipped;
    } hit_result_t;

    logic [rsi_pkg::TOL_WIDTH-1:0] tolerance;
    hit_result_t                   hits_due[$];

    function automatic logic [127:0] floor_sqrt(input logic [127:0] x);
        logic [127:0] res;
        logic [127:0] b;
        logic [127:0] trial;
        res = '0;
        b   = 128'd1 << 126;
        for (int i = 0; i < 64; i++)
        begin
            trial = res + b;
            if (x >= trial)
            begin
                x   = x - trial;
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic hit_result_t predict_hit();
        logic signed [127:0] o[3];
        logic signed [127:0] dv[3];
        logic signed [127:0] d[3];
        logic signed [127:0] rad;
        logic signed [127:0] s;
        logic signed [127:0] a1;
        logic signed [127:0] disc;
        logic signed [127:0] t;
        logic signed [127:0] p;
        logic signed [127:0] cmax;
        logic signed [127:0] cmin;
        logic signed [127:0] tol_wide;
        logic [31:0]         pt[3];
        hit_result_t         r;
        o[0]  = req.origin_x;
        o[1]  = req.origin_y;
        o[2]  = req.origin_z;
        dv[0] = req.dir_x;
        dv[1] = req.dir_y;
        dv[2] = req.dir_z;
        d[0]  = o[0] - 128'(signed'(req.center_x));
        d[1]  = o[1] - 128'(signed'(req.center_y));
        d[2]  = o[2] - 128'(signed'(req.center_z));
        rad   = {97'd0, req.sphere_radius};
        s     = -(rad * rad);
        a1    = '0;
        for (int i = 0; i < 3; i++)
        begin
            s  = s + d[i] * d[i];
            a1 = a1 + dv[i] * d[i];
        end
        disc = a1 * a1 - (s <<< 32);
        r    = '0;
        if (s <= 0)
        begin
            t = -a1 + $signed(floor_sqrt(disc));
        end
        else if (a1 >= 0 || disc < 0)
        begin
            return r;
        end
        else
        begin
            tol_wide = {112'd0, tolerance} << 48;
            if (disc < tol_wide)
                t = -a1;
            else
                t = -a1 - $signed(floor_sqrt(disc));
        end
        cmax = 128'sd2147483647;
        cmin = -128'sd2147483648;
        r.hit = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            p = o[i] + ((t * dv[i] + (128'sd1 <<< 47)) >>> 48);
            if (p > cmax)
            begin
                p = cmax;
                r.clipped = 1'b1;
            end
            else if (p < cmin)
            begin
                p = cmin;
                r.clipped = 1'b1;
            end
            pt[i] = p[31:0];
        end
        r.point_x = pt[0];
        r.point_y = pt[1];
        r.point_z = pt[2];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
    end

    assign pending = hits_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        hit_result_t want;
        if (!rst_n)
        begin
            tolerance <= rsi_pkg::TOL_RESET;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                tolerance <= cfg.tangent_tolerance;
            if (req.valid && req.ready)
                hits_due.push_back(predict_hit());
            if (rsp.valid && rsp.ready)
            begin
                if (hits_due.size() == 0)
                begin
                    report_mismatch("response item with none expected", 32'd0, 32'd0);
                end
                else
                begin
                    want = hits_due.pop_front();
                    if (rsp.hit !== want.hit)
                        report_mismatch("hit", 32'(rsp.hit), 32'(want.hit));
                    if (rsp.point_x !== want.point_x)
                        report_mismatch("point_x", rsp.point_x, want.point_x);
                    if (rsp.point_y !== want.point_y)
                        report_mismatch("point_y", rsp.point_y, want.point_y);
                    if (rsp.point_z !== want.point_z)
                        report_mismatch("point_z", rsp.point_z, want.point_z);
                    if (rsp.clipped !== want.clipped)
                        report_mismatch("clipped", 32'(rsp.clipped), 32'(want.clipped));
                end
            end
        end
    end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives rays and spheres into the intersection block with random gaps and
// response stalls, steps the tangent tolerance through several settings, and
// gives the verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        logic signed [31:0] ox, oy, oz;
        logic signed [17:0] dx, dy, dz;
        logic signed [31:0] cx, cy, cz;
        logic [30:0]        rad;
    } ray_item_t;

    logic clk;
    logic rst_n;
    logic quiet;
    int   fail_count;
    int   pending;

    rsi_req_if req_ch ();
    rsi_rsp_if rsp_ch ();
    rsi_cfg_if cfg_ch ();

    ray_sphere_intersect dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    rsi_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (quiet)
            begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    task automatic send_ray(input ray_item_t it);
        req_ch.valid         <= 1'b1;
        req_ch.origin_x      <= it.ox;
        req_ch.origin_y      <= it.oy;
        req_ch.origin_z      <= it.oz;
        req_ch.dir_x         <= it.dx;
        req_ch.dir_y         <= it.dy;
        req_ch.dir_z         <= it.dz;
        req_ch.center_x      <= it.cx;
        req_ch.center_y      <= it.cy;
        req_ch.center_z      <= it.cz;
        req_ch.sphere_radius <= it.rad;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic write_tolerance(input logic [15:0] value);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        cfg_ch.valid             <= 1'b1;
        cfg_ch.tangent_tolerance <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic ray_item_t make_ray(input logic signed [31:0] ox, oy, oz,
                                           input logic signed [17:0] dx, dy, dz,
                                           input logic signed [31:0] cx, cy, cz,
                                           input logic [30:0] rad);
        ray_item_t it;
        it.ox = ox; it.oy = oy; it.oz = oz;
        it.dx = dx; it.dy = dy; it.dz = dz;
        it.cx = cx; it.cy = cy; it.cz = cz;
        it.rad = rad;
        return it;
    endfunction

    function automatic logic signed [31:0] near_val(input int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic ray_item_t random_ray();
        ray_item_t          it;
        logic signed [31:0] lat1, lat2, reach;
        logic signed [17:0] sgn;
        int                 mode;
        mode = $urandom_range(0, 9);
        it.cx  = near_val(1 << 22);
        it.cy  = near_val(1 << 22);
        it.cz  = near_val(1 << 22);
        it.rad = 31'($urandom_range(1, 1 << 21));
        it.dx  = 18'(near_val(65536));
        it.dy  = 18'(near_val(65536));
        it.dz  = 18'(near_val(65536));
        it.ox  = it.cx + near_val(1 << 23);
        it.oy  = it.cy + near_val(1 << 23);
        it.oz  = it.cz + near_val(1 << 23);
        if (mode <= 4)
        begin
            // Aimed along x toward the sphere with a lateral offset of up to the radius.
            sgn   = ($urandom_range(0, 1) != 0) ? 18'sd65536 : -18'sd65536;
            reach = $urandom_range(it.rad + 1, it.rad + (1 << 22));
            lat1  = near_val(int'(it.rad));
            lat2  = (mode == 4) ? 32'sd0 : near_val(int'(it.rad) / 2);
            if (mode == 3)
                lat1 = $signed({1'b0, it.rad});
            it.dx = sgn;
            it.dy = 18'(near_val(64));
            it.dz = 18'(near_val(64));
            it.ox = (sgn > 0) ? it.cx - reach : it.cx + reach;
            it.oy = it.cy + lat1;
            it.oz = it.cz + lat2;
        end
        else if (mode <= 6)
        begin
            it.ox = it.cx + near_val(int'(it.rad) / 2);
            it.oy = it.cy + near_val(int'(it.rad) / 2);
            it.oz = it.cz + near_val(int'(it.rad) / 2);
        end
        else if (mode == 7)
        begin
            it.ox  = $urandom; it.oy = $urandom; it.oz = $urandom;
            it.cx  = $urandom; it.cy = $urandom; it.cz = $urandom;
            it.dx  = 18'($urandom); it.dy = 18'($urandom); it.dz = 18'($urandom);
            it.rad = 31'($urandom);
        end
        else if (mode == 8)
        begin
            it.rad = 31'($urandom);
            it.dx  = 18'($urandom);
            it.dy  = 18'($urandom);
            it.dz  = 18'($urandom);
        end
        return it;
    endfunction

    initial
    begin
        logic [15:0] tol_steps[5];
        req_ch.valid             = 1'b0;
        req_ch.origin_x          = '0;
        req_ch.origin_y          = '0;
        req_ch.origin_z          = '0;
        req_ch.dir_x             = '0;
        req_ch.dir_y             = '0;
        req_ch.dir_z             = '0;
        req_ch.center_x          = '0;
        req_ch.center_y          = '0;
        req_ch.center_z          = '0;
        req_ch.sphere_radius     = '0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.tangent_tolerance = '0;
        quiet                    = 1'b0;
        rst_n                    = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_ray(make_ray(0, 0, -655360, 0, 0, 65536, 0, 0, 0, 65536));
        send_ray(make_ray(0, 65536, -655360, 0, 0, 65536, 0, 0, 0, 65536));
        send_ray(make_ray(0, 65537, -655360, 0, 0, 65536, 0, 0, 0, 65536));
        send_ray(make_ray(0, 0, 655360, 0, 0, 65536, 0, 0, 0, 65536));
        send_ray(make_ray(0, 0, -655360, 0, 0, 0, 0, 0, 0, 65536));
        send_ray(make_ray(100, 200, 300, 0, 0, 0, 0, 0, 0, 65536));
        send_ray(make_ray(0, 0, 0, 65536, 0, 0, 0, 0, 0, 0));
        send_ray(make_ray(0, 0, 0, 0, -65536, 0, 0, 0, 0, 31'h7fffffff));
        send_ray(make_ray(32'sh7fffffff, 0, 0, 65536, 0, 0, 0, 0, 0, 31'h7fffffff));
        send_ray(make_ray(-32'sh80000000, -32'sh80000000, -32'sh80000000,
                          -18'sd131072, -18'sd131072, -18'sd131072,
                          32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff));
        send_ray(make_ray(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                          18'sd131071, 18'sd131071, 18'sd131071,
                          -32'sh80000000, -32'sh80000000, -32'sh80000000, 0));
        send_ray(make_ray(-32'sh80000000, 0, 0, 18'sd131071, 0, 0,
                          32'sh7fffffff, 0, 0, 31'h7fffffff));
        send_ray(make_ray(0, 0, 0, 18'sd131071, 18'sd131071, 0, 0, 0, 0, 31'h7fffffff));
        send_ray(make_ray(-655360, 0, 0, 46341, 46341, 0, 0, 0, 0, 65536));
        send_ray(make_ray(0, 0, 0, 65536, 0, 0, 0, 0, 0, 65536));

        tol_steps[0] = 16'd0;
        tol_steps[1] = 16'hffff;
        tol_steps[2] = 16'($urandom);
        tol_steps[3] = 16'd1;
        tol_steps[4] = 16'($urandom_range(2, 64));
        for (int ph = 0; ph < 5; ph++)
        begin
            write_tolerance(tol_steps[ph]);
            if (ph == 4)
                quiet = 1'b1;
            for (int n = 0; n < 340; n++)
                send_ray(random_ray());
        end
        req_ch.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/rsi_pkg.sv
hw/rtl/rsi_if.sv
hw/rtl/rsi_queue.sv
hw/rtl/rsi_front.sv
hw/rtl/rsi_back.sv
hw/rtl/ray_sphere_intersect.sv
verif/rsi_checker.sv
verif/testbench.sv
